// File: hdl/tfc_pkg.sv
// shared types and constants for the typeahead fifo with flow control
package tfc_pkg;

  localparam int FifoDepth = 32;
  localparam int NumChan   = 2;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int KeyW      = 32;
  localparam int FuncW     = 2;
  localparam int ChanW     = 1;

  typedef enum logic [FuncW-1:0] {
    FuncKey    = 2'd0,
    FuncRead   = 2'd1,
    FuncStatus = 2'd2
  } func_e;

  localparam logic [7:0] CharCtrlC = 8'h03;
  localparam logic [7:0] CharCtrlQ = 8'h11;
  localparam logic [7:0] CharCtrlS = 8'h13;
  localparam logic [7:0] CharCtrlX = 8'h18;

  // request from the channel control to the key store
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ChanW-1:0] ch;
    logic [PtrW-1:0]  waddr;
    logic [PtrW-1:0]  raddr;
    logic [KeyW-1:0]  wdata;
  } ram_req_t;

  // per-word status flags
  typedef struct packed {
    logic read_valid;
    logic keys_pending;
    logic bell;
    logic abort_request;
    logic output_stopped;
  } res_flags_t;

endpackage

// File: hdl/typeahead_fifo_flow_control.sv
// top level of the two-channel keyboard typeahead fifo with xon/xoff control
//
// Each accepted word yields exactly one result word in the cycle after its
// acceptance: the channel state (pointers, fill count, stop flag) and
// the key store update at the edge that accepts the word, and the key
// store's registered read port captures read_data at that same edge. A new
// word is accepted every cycle while the result register is empty or
// being drained; a stalled result holds the input off. Each channel keeps
// up to 32 key words; the store needs no clearing after reset since only
// counted entries are ever read.
module typeahead_fifo_flow_control (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tfc_pkg::FuncW-1:0] func_i,
  input  logic [tfc_pkg::ChanW-1:0] channel_i,
  input  logic [tfc_pkg::KeyW-1:0]  key_code_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tfc_pkg::KeyW-1:0]  read_data_o,
  output logic                      read_valid_o,
  output logic                      keys_pending_o,
  output logic                      bell_o,
  output logic                      abort_request_o,
  output logic                      output_stopped_o
);
  import tfc_pkg::*;

  logic            accept;
  logic            out_valid_q, out_valid_d;
  res_flags_t      flags_d, flags_q;
  ram_req_t        ram_req;
  logic [KeyW-1:0] rdata;

  // result register may take a new word when empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // decode and per-channel state
  tfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .channel_i  (channel_i),
    .key_code_i (key_code_i),
    .ram_req_o  (ram_req),
    .flags_o    (flags_d)
  );

  // key store, read data lands alongside the result flags
  tfc_key_ram u_key_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result flags, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
    end
  end

  // read data only reported on a successful read, zero otherwise
  assign out_valid_o      = out_valid_q;
  assign read_data_o      = flags_q.read_valid ? rdata : '0;
  assign read_valid_o     = flags_q.read_valid;
  assign keys_pending_o   = flags_q.keys_pending;
  assign bell_o           = flags_q.bell;
  assign abort_request_o  = flags_q.abort_request;
  assign output_stopped_o = flags_q.output_stopped;

endmodule

// File: hdl/tfc_key_ram.sv
// key store memory for both channels, one write and one registered read port
module tfc_key_ram (
  input  logic                    clk_i,
  input  tfc_pkg::ram_req_t       req_i,
  output logic [tfc_pkg::KeyW-1:0] rdata_o
);
  import tfc_pkg::*;

  logic [KeyW-1:0] mem_q [NumChan][FifoDepth];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.ch][req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.ch][req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tfc_ctrl.sv
// per-channel pointers, fill counts and stop flags with key decode
module tfc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [tfc_pkg::FuncW-1:0] func_i,
  input  logic [tfc_pkg::ChanW-1:0] channel_i,
  input  logic [tfc_pkg::KeyW-1:0]  key_code_i,
  output tfc_pkg::ram_req_t         ram_req_o,
  output tfc_pkg::res_flags_t       flags_o
);
  import tfc_pkg::*;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FifoDepth - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  logic [PtrW-1:0] wp_q  [NumChan];
  logic [PtrW-1:0] rp_q  [NumChan];
  logic [CntW-1:0] cnt_q [NumChan];
  logic            stop_q [NumChan];

  logic [PtrW-1:0] wp_d, rp_d;
  logic [CntW-1:0] cnt_d;
  logic            stop_d;
  logic [PtrW-1:0] base_wp;
  logic [CntW-1:0] base_cnt;
  logic [7:0]      chr;
  logic            push, pop, bell, abort_req;
  func_e           func;

  assign chr  = key_code_i[7:0];
  assign func = func_e'(func_i);

  always_comb begin
    wp_d      = wp_q[channel_i];
    rp_d      = rp_q[channel_i];
    cnt_d     = cnt_q[channel_i];
    stop_d    = stop_q[channel_i];
    base_wp   = wp_q[channel_i];
    base_cnt  = cnt_q[channel_i];
    push      = 1'b0;
    pop       = 1'b0;
    bell      = 1'b0;
    abort_req = 1'b0;
    unique case (func)
      FuncKey: begin
        if (chr == CharCtrlC) begin
          wp_d      = '0;
          rp_d      = '0;
          cnt_d     = '0;
          stop_d    = 1'b0;
          abort_req = 1'b1;
        end else if (chr == CharCtrlS) begin
          stop_d = 1'b1;
        end else if (chr == CharCtrlQ) begin
          stop_d = 1'b0;
        end else begin
          // ctrl-x empties the channel, then is stored like any key
          if (chr == CharCtrlX) begin
            base_wp  = '0;
            base_cnt = '0;
            rp_d     = '0;
          end
          wp_d  = base_wp;
          cnt_d = base_cnt;
          if (base_cnt >= CntW'(FifoDepth)) begin
            bell = 1'b1;
          end else begin
            push  = 1'b1;
            wp_d  = ptr_next(base_wp);
            cnt_d = base_cnt + 1'b1;
          end
        end
      end
      FuncRead: begin
        if (!stop_q[channel_i] && cnt_q[channel_i] != '0) begin
          pop   = 1'b1;
          cnt_d = cnt_q[channel_i] - 1'b1;
          if (cnt_d == '0) begin
            wp_d = '0;
            rp_d = '0;
          end else begin
            rp_d = ptr_next(rp_q[channel_i]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        wp_q[i]   <= '0;
        rp_q[i]   <= '0;
        cnt_q[i]  <= '0;
        stop_q[i] <= 1'b0;
      end
    end else if (accept_i) begin
      wp_q[channel_i]   <= wp_d;
      rp_q[channel_i]   <= rp_d;
      cnt_q[channel_i]  <= cnt_d;
      stop_q[channel_i] <= stop_d;
    end
  end

  always_comb begin
    ram_req_o.we    = accept_i && push;
    ram_req_o.re    = accept_i && pop;
    ram_req_o.ch    = channel_i;
    ram_req_o.waddr = base_wp;
    ram_req_o.raddr = rp_q[channel_i];
    ram_req_o.wdata = key_code_i;
  end

  always_comb begin
    flags_o.read_valid     = pop;
    flags_o.keys_pending   = (cnt_d != '0);
    flags_o.bell           = bell;
    flags_o.abort_request  = abort_req;
    flags_o.output_stopped = stop_d;
  end

endmodule

// File: bench/typeahead_fifo_flow_control_tb.sv
// self-checking bench for the typeahead fifo with xon/xoff flow control
module typeahead_fifo_flow_control_tb;
  import tfc_pkg::*;

  // func code outside the enum, handled like a status query
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  localparam int DirRows     = 22;
  localparam int PhaseItems  = 250;
  localparam int HoldCycles  = 120;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 400000;

  // one result word as the block reports it
  typedef struct packed {
    logic [KeyW-1:0] data;
    logic            rv;
    logic            kp;
    logic            bell;
    logic            abrt;
    logic            stp;
  } key_result_t;

  // directed row: input word, plus a hand-written result where typed is set
  typedef struct packed {
    logic [FuncW-1:0] f;
    logic [ChanW-1:0] ch;
    logic [KeyW-1:0]  key;
    logic             typed;
    key_result_t      res;
  } stim_row_t;

  // random burst shapes
  typedef enum int {
    BurstFill,
    BurstDrain,
    BurstMixed,
    BurstNoise
  } burst_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [FuncW-1:0] func_i;
  logic [ChanW-1:0] channel_i;
  logic [KeyW-1:0]  key_code_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [KeyW-1:0]  read_data_o;
  logic             read_valid_o;
  logic             keys_pending_o;
  logic             bell_o;
  logic             abort_request_o;
  logic             output_stopped_o;

  // predicted per-channel fifo state
  logic [KeyW-1:0] key_mem [NumChan][FifoDepth];
  int              wr_idx  [NumChan];
  int              rd_idx  [NumChan];
  int              fill    [NumChan];
  logic            stopped [NumChan];

  key_result_t reply_fifo [$];
  int          mismatches;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  stim_row_t   dir_tab [DirRows];

  typeahead_fifo_flow_control DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .channel_i        (channel_i),
    .key_code_i       (key_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .read_valid_o     (read_valid_o),
    .keys_pending_o   (keys_pending_o),
    .bell_o           (bell_o),
    .abort_request_o  (abort_request_o),
    .output_stopped_o (output_stopped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic int step_idx(int p);
    return (p + 1 >= FifoDepth) ? 0 : p + 1;
  endfunction

  // empty a channel and rewind both pointers
  function automatic void drop_channel(logic [ChanW-1:0] ch);
    wr_idx[ch] = 0;
    rd_idx[ch] = 0;
    fill[ch]   = 0;
  endfunction

  // apply one accepted word to the predicted state, return its result word
  function automatic key_result_t keyboard_step(logic [FuncW-1:0] f, logic [ChanW-1:0] ch,
                                                logic [KeyW-1:0] key);
    key_result_t r;
    logic [7:0]  c;
    r = '0;
    c = key[7:0];
    if (f == FuncKey) begin
      if (c == CharCtrlC) begin
        // interrupt: flush, release the hold, raise abort
        drop_channel(ch);
        stopped[ch] = 1'b0;
        r.abrt      = 1'b1;
      end else if (c == CharCtrlS) begin
        stopped[ch] = 1'b1;
      end else if (c == CharCtrlQ) begin
        stopped[ch] = 1'b0;
      end else begin
        // cancel-line flushes first and is then stored like any key
        if (c == CharCtrlX) drop_channel(ch);
        if (fill[ch] >= FifoDepth) begin
          r.bell = 1'b1;
        end else begin
          key_mem[ch][wr_idx[ch]] = key;
          wr_idx[ch] = step_idx(wr_idx[ch]);
          fill[ch]++;
        end
      end
    end else if (f == FuncRead) begin
      // no pop while held or empty
      if (!stopped[ch] && fill[ch] != 0) begin
        r.data     = key_mem[ch][rd_idx[ch]];
        r.rv       = 1'b1;
        rd_idx[ch] = step_idx(rd_idx[ch]);
        fill[ch]--;
        if (fill[ch] == 0) drop_channel(ch);
      end
    end
    // status query and the unused code leave the state alone
    r.kp  = (fill[ch] != 0);
    r.stp = stopped[ch];
    return r;
  endfunction

  // random key word, with a control character in ctrl_pct percent of cases
  function automatic logic [KeyW-1:0] rand_key(int ctrl_pct);
    logic [KeyW-1:0] w;
    w = $urandom;
    if ($urandom_range(99) < ctrl_pct) begin
      case ($urandom_range(3))
        0:       w[7:0] = CharCtrlC;
        1:       w[7:0] = CharCtrlS;
        2:       w[7:0] = CharCtrlQ;
        default: w[7:0] = CharCtrlX;
      endcase
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // offer one word, called just after a rising edge; on acceptance the
  // expected result is queued, hand-written for typed directed rows
  task automatic send_word(input logic [FuncW-1:0] f, input logic [ChanW-1:0] ch,
                           input logic [KeyW-1:0] key, input logic typed,
                           input key_result_t typed_res);
    key_result_t pred;
    // random sender gap, with valid dropped before the word is offered
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    channel_i  <= ch;
    key_code_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = keyboard_step(f, ch, key);
    reply_fifo.push_back(typed ? typed_res : pred);
  endtask

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic flag_mismatch(input string field, input logic [KeyW-1:0] want,
                               input logic [KeyW-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // every accepted result word is checked against the oldest expectation
  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_fifo.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, expected none, actual %h", $time,
                 read_data_o);
      end else begin
        want = reply_fifo.pop_front();
        if (read_data_o !== want.data)
          flag_mismatch("read_data", want.data, read_data_o);
        if (read_valid_o !== want.rv)
          flag_mismatch("read_valid", KeyW'(want.rv), KeyW'(read_valid_o));
        if (keys_pending_o !== want.kp)
          flag_mismatch("keys_pending", KeyW'(want.kp), KeyW'(keys_pending_o));
        if (bell_o !== want.bell)
          flag_mismatch("bell", KeyW'(want.bell), KeyW'(bell_o));
        if (abort_request_o !== want.abrt)
          flag_mismatch("abort_request", KeyW'(want.abrt), KeyW'(abort_request_o));
        if (output_stopped_o !== want.stp)
          flag_mismatch("output_stopped", KeyW'(want.stp), KeyW'(output_stopped_o));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("typeahead_fifo_flow_control_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  initial begin
    burst_e           kind;
    int               len;
    int               sent;
    int               r;
    int               ctrl_pct;
    logic [ChanW-1:0] bch;
    logic [ChanW-1:0] ch;
    logic [FuncW-1:0] f;
    logic [KeyW-1:0]  key;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FuncStatus;
    channel_i   = '0;
    key_code_i  = '0;
    mismatches  = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < NumChan; i++) begin
      wr_idx[i]  = 0;
      rd_idx[i]  = 0;
      fill[i]    = 0;
      stopped[i] = 1'b0;
    end

    // directed words; typed result is {read_data, rv kp bell abort stop}
    dir_tab = '{
      // after reset: status, empty read, unused code
      {FuncStatus, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 5'b00000},
      {FuncRead,   1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 5'b00000},
      {FuncUnused, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 5'b00000},
      // all-ones and all-zeros key words, then pop the older
      {FuncKey,    1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 5'b01000},
      {FuncKey,    1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncRead,   1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 5'b11000},
      // hold: not stored, read refused while held
      {FuncKey,    1'b0, 32'h0000_0013, 1'b1, 32'h0000_0000, 5'b01001},
      {FuncRead,   1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 5'b01001},
      {FuncStatus, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 5'b00000},
      // release with upper bits set, pop the last key, then empty read
      {FuncKey,    1'b0, 32'hABCD_EF11, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncRead,   1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncRead,   1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 5'b00000},
      // cancel-line on empty and on a filled channel
      {FuncKey,    1'b1, 32'h1234_5618, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncKey,    1'b1, 32'h8000_0041, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncKey,    1'b1, 32'h0000_0118, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncRead,   1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 5'b00000},
      // interrupt flushes and also releases a hold
      {FuncKey,    1'b1, 32'h7FFF_FF41, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncKey,    1'b1, 32'h0000_0013, 1'b0, 32'h0000_0000, 5'b00000},
      {FuncKey,    1'b1, 32'hFFFF_FF03, 1'b1, 32'h0000_0000, 5'b00010},
      {FuncStatus, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 5'b00000},
      {FuncKey,    1'b0, 32'h0000_0003, 1'b1, 32'h0000_0000, 5'b00010},
      {FuncStatus, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 5'b00000}
    };

    // reset held, then released on an edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling on either side
    for (int i = 0; i < DirRows; i++)
      send_word(dir_tab[i].f, dir_tab[i].ch, dir_tab[i].key, dir_tab[i].typed,
                dir_tab[i].res);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_fifo.size() != 0);

    // random phases: receiver-heavy idling, sender-heavy idling, none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // long receiver hold-off while words keep coming
          hold_req = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 30)      kind = BurstFill;
        else if (r < 55) kind = BurstDrain;
        else if (r < 85) kind = BurstMixed;
        else             kind = BurstNoise;
        // fill bursts can run long enough to overflow a channel
        len = (kind == BurstFill) ? $urandom_range(70, 30) : $urandom_range(40, 8);
        bch = ChanW'($urandom_range(1));
        for (int n = 0; n < len && sent < PhaseItems; n++) begin
          ch = ($urandom_range(99) < 85) ? bch : ~bch;
          r  = $urandom_range(99);
          case (kind)
            BurstFill: begin
              f = (r < 85) ? FuncKey : (r < 95) ? FuncRead : FuncStatus;
              ctrl_pct = 2;
            end
            BurstDrain: begin
              f = (r < 75) ? FuncRead : (r < 95) ? FuncKey : FuncStatus;
              ctrl_pct = 25;
            end
            BurstMixed: begin
              f = (r < 45) ? FuncKey : (r < 90) ? FuncRead : FuncStatus;
              ctrl_pct = 12;
            end
            default: begin
              // noise: any code, any channel, any word
              f  = FuncW'($urandom_range(3));
              ch = ChanW'($urandom_range(1));
              ctrl_pct = 0;
            end
          endcase
          key = rand_key(ctrl_pct);
          send_word(f, ch, key, 1'b0, '0);
          sent++;
        end
      end
      // sender pauses until every result word is back
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (reply_fifo.size() != 0);
    end

    // settle, then report
    repeat (DrainCycles) @(posedge clk_i);
    if (reply_fifo.size() != 0) begin
      mismatches++;
      $display("%0t: result words missing, expected %0d more, actual 0", $time,
               reply_fifo.size());
    end
    if (mismatches == 0)
      $display("typeahead_fifo_flow_control_tb: done, clean");
    else
      $display("typeahead_fifo_flow_control_tb: done, errors");
    $finish;
  end

endmodule
